// File: rtl/integer_to_ascii_formatter_defines.svh
// assertion macros shared by the checker files of the integer to ascii formatter
// no dependencies; every macro expects i_clk and i_rst_n in scope
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, quiet during reset
`define I2A_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock, quiet during reset
`define I2A_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/i2a_pkg.sv
// shared constants of the integer to ascii formatter: base codes, characters, widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

    // field widths
    localparam int VALUE_W = 32;
    localparam int BASE_W  = 2;
    localparam int WIDTH_W = 4;
    localparam int CHAR_W  = 8;

    // base codes, anything else prints as hex
    localparam logic [BASE_W-1:0] BASE_OCT = 2'd0;
    localparam logic [BASE_W-1:0] BASE_DEC = 2'd1;
    localparam logic [BASE_W-1:0] BASE_HEX = 2'd2;

    // digit store and character counters
    localparam int DIGIT_DEPTH = 11;
    localparam int CNT_W       = 4;
    localparam int DIGIT_W     = 4;

    // minimum width limits
    localparam logic [WIDTH_W-1:0] WIDTH_MIN = 4'd1;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX = 4'd9;

    // divide by ten: q = (v * RECIP_10) >> DEC_SHIFT, exact for any 32-bit v
    localparam logic [VALUE_W-1:0] RECIP_10  = 32'hCCCC_CCCD;
    localparam int                 DEC_SHIFT = 35;
    localparam int                 QUOT_W    = 2 * VALUE_W - DEC_SHIFT;

    // characters
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [CHAR_W-1:0] DIGIT_CHARS [0:15] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

endpackage

`default_nettype wire

// File: rtl/i2a_radix_unit.sv
// shared radix step: splits a value into quotient and lowest digit for base 8, 10 or 16
// depends on i2a_pkg; decimal uses a registered reciprocal multiply
`timescale 1ns / 1ps
`default_nettype none

module i2a_radix_unit (
    input  wire logic                          i_clk,
    input  wire logic [i2a_pkg::VALUE_W-1:0]   i_val,
    input  wire logic [i2a_pkg::BASE_W-1:0]    i_base,
    output logic      [i2a_pkg::VALUE_W-1:0]   o_quot,
    output logic      [i2a_pkg::DIGIT_W-1:0]   o_rem
);

    logic [2*i2a_pkg::VALUE_W-1:0] w_prod;
    logic [i2a_pkg::QUOT_W-1:0]    r_quot10;
    logic [i2a_pkg::DIGIT_W-1:0]   w_q10_lo;

    // reciprocal multiply, registered before use; valid in the cycle after i_val settles
    assign w_prod = {{i2a_pkg::VALUE_W{1'b0}}, i_val}
                  * {{i2a_pkg::VALUE_W{1'b0}}, i2a_pkg::RECIP_10};

    always_ff @(posedge i_clk) begin
        r_quot10 <= w_prod[2*i2a_pkg::VALUE_W-1:i2a_pkg::DEC_SHIFT];
    end

    // low four bits of quotient times ten, enough since the remainder is below ten
    assign w_q10_lo = {r_quot10[0], 3'b000} + {r_quot10[2:0], 1'b0};

    // quotient and digit by base
    always_comb begin
        case (i_base)
            i2a_pkg::BASE_OCT: begin
                o_quot = {3'b000, i_val[i2a_pkg::VALUE_W-1:3]};
                o_rem  = {1'b0, i_val[2:0]};
            end
            i2a_pkg::BASE_DEC: begin
                o_quot = {{(i2a_pkg::VALUE_W-i2a_pkg::QUOT_W){1'b0}}, r_quot10};
                o_rem  = i_val[3:0] - w_q10_lo;
            end
            default: begin
                o_quot = {4'b0000, i_val[i2a_pkg::VALUE_W-1:4]};
                o_rem  = i_val[3:0];
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/integer_to_ascii_formatter.sv
// top level of the integer to ascii formatter: sequencer, digit store, character output
// depends on i2a_pkg and i2a_radix_unit
`timescale 1ns / 1ps
`default_nettype none

// Prints one 32-bit number per input word as ASCII text, one character per output
// word, most significant first, the final character marked by tlast. Digits come from
// a single shared radix unit, lowest digit first, into a small digit store: octal and
// hex give a digit in each digit step, decimal passes through a reciprocal multiply
// state and then the reduce state for each digit. The characters, padding and sign
// included, then leave at one per cycle through an output register while the output
// is not stalled. The next word is taken as soon as the last character sits in the
// output register, even if it has not yet been taken.
module integer_to_ascii_formatter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // value [31:0], zero_pad [32], min_width [36:33], zero fill [39:37]
    input  wire logic [39:0] s_axis_tdata,
    // base_select [1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // char_out [7:0]
    output logic      [7:0]  m_axis_tdata,
    output logic             m_axis_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIG  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]                       r_state, n_state;
    logic [i2a_pkg::VALUE_W-1:0]      r_val;
    logic [i2a_pkg::BASE_W-1:0]       r_base;
    logic                             r_zpad;
    logic                             r_neg;
    logic [i2a_pkg::WIDTH_W-1:0]      r_width;
    logic [i2a_pkg::CNT_W-1:0]        r_ndig;
    logic [i2a_pkg::CNT_W-1:0]        r_k;
    logic [i2a_pkg::DIGIT_W-1:0]      r_digits [0:i2a_pkg::DIGIT_DEPTH-1];
    logic                             r_out_valid;
    logic [i2a_pkg::CHAR_W-1:0]       r_out_char;
    logic                             r_out_last;

    logic [i2a_pkg::VALUE_W-1:0]      w_in_val;
    logic [i2a_pkg::BASE_W-1:0]       w_in_base;
    logic [i2a_pkg::WIDTH_W-1:0]      w_in_width;
    logic                             w_in_neg;
    logic                             w_accept;
    logic [i2a_pkg::VALUE_W-1:0]      w_quot;
    logic [i2a_pkg::DIGIT_W-1:0]      w_rem;
    logic [i2a_pkg::CNT_W-1:0]        w_sign;
    logic [i2a_pkg::CNT_W-1:0]        w_body;
    logic [i2a_pkg::CNT_W-1:0]        w_total;
    logic [i2a_pkg::CNT_W-1:0]        w_pad;
    logic [i2a_pkg::CNT_W-1:0]        w_rd_idx;
    logic [i2a_pkg::CHAR_W-1:0]       w_char;
    logic                             w_last;
    logic                             w_out_free;

    // input word fields
    assign w_in_val   = s_axis_tdata[31:0];
    assign w_in_base  = s_axis_tuser;
    assign w_in_neg   = (w_in_base == i2a_pkg::BASE_DEC) && w_in_val[31];
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // clamp the minimum width into 1..9
    always_comb begin
        w_in_width = s_axis_tdata[36:33];
        if (w_in_width < i2a_pkg::WIDTH_MIN) begin
            w_in_width = i2a_pkg::WIDTH_MIN;
        end else if (w_in_width > i2a_pkg::WIDTH_MAX) begin
            w_in_width = i2a_pkg::WIDTH_MAX;
        end
    end

    i2a_radix_unit u_radix (
        .i_clk  (i_clk),
        .i_val  (r_val),
        .i_base (r_base),
        .o_quot (w_quot),
        .o_rem  (w_rem)
    );

    // layout of the printed field
    assign w_sign   = {3'b000, r_neg};
    assign w_body   = r_ndig + w_sign;
    assign w_total  = (w_body > r_width) ? w_body : r_width;
    assign w_pad    = w_total - w_body;
    assign w_rd_idx = w_total - 4'd1 - r_k;
    assign w_last   = (r_k == w_total - 4'd1);

    // character at position r_k
    always_comb begin
        w_char = i2a_pkg::DIGIT_CHARS[r_digits[w_rd_idx]];
        if (r_zpad) begin
            if (r_neg && r_k == '0) begin
                w_char = i2a_pkg::CHAR_MINUS;
            end else if (r_k < w_pad + w_sign) begin
                w_char = i2a_pkg::CHAR_ZERO;
            end
        end else begin
            if (r_k < w_pad) begin
                w_char = i2a_pkg::CHAR_SPACE;
            end else if (r_neg && r_k == w_pad) begin
                w_char = i2a_pkg::CHAR_MINUS;
            end
        end
    end

    assign w_out_free = !r_out_valid || m_axis_tready;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (w_in_base == i2a_pkg::BASE_DEC) ? ST_MUL : ST_DIG;
                end
            end
            ST_MUL: begin
                n_state = ST_DIG;
            end
            ST_DIG: begin
                if (w_quot == '0) begin
                    n_state = ST_EMIT;
                end else if (r_base == i2a_pkg::BASE_DEC) begin
                    n_state = ST_MUL;
                end
            end
            ST_EMIT: begin
                if (w_out_free && w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_ndig      <= '0;
            r_k         <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_ndig <= '0;
                r_k    <= '0;
            end else if (r_state == ST_DIG) begin
                r_ndig <= r_ndig + 4'd1;
            end else if (r_state == ST_EMIT && w_out_free) begin
                r_k <= r_k + 4'd1;
            end
            if (r_state == ST_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_val   <= w_in_neg ? (32'd0 - w_in_val) : w_in_val;
            r_base  <= w_in_base;
            r_zpad  <= s_axis_tdata[32];
            r_neg   <= w_in_neg;
            r_width <= w_in_width;
        end else if (r_state == ST_DIG) begin
            r_val <= w_quot;
        end
        if (r_state == ST_DIG) begin
            r_digits[r_ndig] <= w_rem;
        end
        if (r_state == ST_EMIT && w_out_free) begin
            r_out_char <= w_char;
            r_out_last <= w_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// File: rtl/i2a_checker.sv
// port-level checks of the integer to ascii formatter, bound to the top level
// depends on integer_to_ascii_formatter_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "integer_to_ascii_formatter_defines.svh"

module i2a_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast
);

    logic       w_in_take;
    logic       w_out_stall;
    logic       w_mid_stall;
    logic       w_open_busy;
    logic [9:0] w_out_word;

    // handshake views of the ports
    assign w_in_take   = s_axis_tvalid && s_axis_tready;
    assign w_out_stall = m_axis_tvalid && !m_axis_tready;
    assign w_mid_stall = w_out_stall && !m_axis_tlast;
    assign w_open_busy = s_axis_tready && m_axis_tvalid;
    assign w_out_word  = {m_axis_tvalid, m_axis_tlast, m_axis_tdata};

    // a stalled output word stays put
    `I2A_ASSERT_NEXT(a_out_hold, w_out_stall, $stable(w_out_word), "stalled output word changed")

    // one number at a time: input closes right after a word is taken
    `I2A_ASSERT_NEXT(a_busy_after_accept, w_in_take, !s_axis_tready, "input open after an accept")

    // when open for a new word, only the last character may still wait
    `I2A_ASSERT(a_idle_only_last, w_open_busy, m_axis_tlast, "input open mid number")

    // a stalled character that is not last keeps the input closed in the next cycle
    `I2A_ASSERT_NEXT(a_no_early_ready, w_mid_stall, !s_axis_tready, "input reopened mid number")

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
